[rtl/core/account_ledger_table_macros.svh]
// ----------------------------------------------------------------------------
// Account ledger table assertion macros
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ACCOUNT_LEDGER_TABLE_MACROS_SVH
`define ACCOUNT_LEDGER_TABLE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ALT_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("account ledger table assertion failed");

// Check a property on every rising clock edge, reset included.
`define ALT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("account ledger table assertion failed");

`endif

[rtl/core/alt_pkg.sv]
// ----------------------------------------------------------------------------
// Account ledger table package
// Shared types and constants for the ledger cells and the top level.
// ----------------------------------------------------------------------------
package alt_pkg;

  localparam int NumAccounts = 64;
  localparam int CntW        = $clog2(NumAccounts + 1);

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_GET      = 3'd1,
    OP_TRADE    = 3'd2,
    OP_ADJUST   = 3'd3,
    OP_QUERY    = 3'd4,
    OP_CLEAR    = 3'd5,
    OP_RSVD6    = 3'd6,
    OP_RSVD7    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOOK = 2'd1,
    S_UPD  = 2'd2,
    S_RD   = 2'd3
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [31:0]        acct_id;
    logic [31:0]        cpty_id;
    logic               taker_sells;
    logic [31:0]        price;
    logic [30:0]        quantity;
    logic signed [63:0] amount;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] balance;
    logic signed [63:0] position;
    logic [63:0]        trades_done;
    logic [63:0]        traded_volume;
    logic               sufficient;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] bal;
    logic [63:0] pos;
    logic [63:0] cnt;
    logic [63:0] vol;
  } entry_t;

  typedef struct packed {
    logic [31:0] acct_id;
    logic [31:0] cpty_id;
    logic        taker_sells;
    logic [30:0] qty;
    logic [63:0] notional;
    logic [63:0] amount;
    logic        trade_go;
    logic        adjust_go;
  } cmd_t;

  typedef struct packed {
    logic   found;
    entry_t entry;
  } rd_t;

endpackage

[rtl/core/alt_cell.sv]
// ----------------------------------------------------------------------------
// Ledger cell
// One account entry: id match, trade/adjust/create update, read chain stage.
// ----------------------------------------------------------------------------
module alt_cell (
  input  logic          clk,
  input  logic          valid,
  input  logic          create_en,
  input  alt_pkg::cmd_t cmd,
  input  alt_pkg::rd_t  rd_in,
  output alt_pkg::rd_t  rd_out,
  output logic          maker_hit,
  output logic          taker_hit
);

  alt_pkg::entry_t entry_r;
  alt_pkg::entry_t entry_nxt;
  logic [63:0]     q64;

  assign maker_hit = valid && (entry_r.id == cmd.acct_id);
  assign taker_hit = valid && (entry_r.id == cmd.cpty_id);
  assign q64       = {33'd0, cmd.qty};

  always_comb begin
    entry_nxt = entry_r;
    if (create_en) begin
      entry_nxt.id  = cmd.acct_id;
      entry_nxt.bal = cmd.amount;
      entry_nxt.pos = '0;
      entry_nxt.cnt = '0;
      entry_nxt.vol = '0;
    end else if (cmd.trade_go && (maker_hit || taker_hit)) begin
      if (maker_hit && taker_hit) begin
        entry_nxt.cnt = entry_r.cnt + 64'd2;
        entry_nxt.vol = entry_r.vol + {q64[62:0], 1'b0};
      end else begin
        entry_nxt.cnt = entry_r.cnt + 64'd1;
        entry_nxt.vol = entry_r.vol + q64;
        if (taker_hit == cmd.taker_sells) begin
          entry_nxt.bal = entry_r.bal + cmd.notional;
          entry_nxt.pos = entry_r.pos - q64;
        end else begin
          entry_nxt.bal = entry_r.bal - cmd.notional;
          entry_nxt.pos = entry_r.pos + q64;
        end
      end
    end else if (cmd.adjust_go && maker_hit) begin
      entry_nxt.bal = entry_r.bal + cmd.amount;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // pass read data down the row; ids are unique so at most one cell hits
  always_comb begin
    rd_out = rd_in;
    if (maker_hit) begin
      rd_out.found = 1'b1;
      rd_out.entry = entry_r;
    end
  end

endmodule

[rtl/core/account_ledger_table.sv]
// ----------------------------------------------------------------------------
// Account ledger table
// Row of account cells with create, trade, adjust, query and clear.
// ----------------------------------------------------------------------------
//  channel | direction | payload       | handshake
//  in_     | input     | alt_pkg::in_t | in_valid / in_ready
//  out_    | output    | out_t         | out_valid / out_ready
//  cfg_    | input     | capacity 7b   | cfg_valid / cfg_ready (always 1)
//
//  Each item passes through accept, id match and multiply, cell update and
//  readback through the cell row. One item is in the row at a time.
//  The result register frees the row; a stalled result blocks only the
//  readback of the following item. Reset empties the table, capacity 64.
// ----------------------------------------------------------------------------
module account_ledger_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  alt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output alt_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_data
);

  alt_pkg::state_t state_r, state_nxt;
  alt_pkg::in_t    in_r;
  logic [alt_pkg::CntW-1:0] count_r, count_nxt;
  logic [6:0]      cap_r;
  logic [63:0]     notional_r;
  logic            mfound_r, tfound_r;
  alt_pkg::status_t status_r, status_nxt;
  logic            out_valid_r;
  alt_pkg::out_t   out_r;

  alt_pkg::cmd_t   cmd;
  alt_pkg::rd_t    chain [alt_pkg::NumAccounts+1];
  logic [alt_pkg::NumAccounts-1:0] mhit, thit, create_sel;
  logic            full, do_create, load_out;
  alt_pkg::op_t    op;

  assign op        = alt_pkg::op_t'(in_r.operation);
  assign full      = ({1'b0, count_r} >= {1'b0, cap_r}) ||
                     (count_r >= alt_pkg::CntW'(alt_pkg::NumAccounts));
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == alt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load_out  = (state_r == alt_pkg::S_RD) && (!out_valid_r || out_ready);

  assign chain[0] = '0;

  for (genvar i = 0; i < alt_pkg::NumAccounts; i++) begin : g_cell
    logic valid_i;
    assign valid_i       = (count_r > alt_pkg::CntW'(i));
    assign create_sel[i] = do_create && (count_r == alt_pkg::CntW'(i));
    alt_cell u_cell (
      .clk       (clk),
      .valid     (valid_i),
      .create_en (create_sel[i]),
      .cmd       (cmd),
      .rd_in     (chain[i]),
      .rd_out    (chain[i+1]),
      .maker_hit (mhit[i]),
      .taker_hit (thit[i])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    do_create  = 1'b0;
    cmd.acct_id     = in_r.acct_id;
    cmd.cpty_id     = in_r.cpty_id;
    cmd.taker_sells = in_r.taker_sells;
    cmd.qty         = in_r.quantity;
    cmd.notional    = notional_r;
    cmd.amount      = in_r.amount;
    cmd.trade_go    = 1'b0;
    cmd.adjust_go   = 1'b0;
    unique case (state_r)
      alt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = alt_pkg::S_LOOK;
        end
      end
      alt_pkg::S_LOOK: begin
        state_nxt = alt_pkg::S_UPD;
      end
      alt_pkg::S_UPD: begin
        state_nxt  = alt_pkg::S_RD;
        status_nxt = alt_pkg::ST_DONE;
        unique case (op) inside
          alt_pkg::OP_CREATE, alt_pkg::OP_GET: begin
            if (mfound_r) begin
              if (op == alt_pkg::OP_CREATE) status_nxt = alt_pkg::ST_EXISTS;
            end else if (full) begin
              status_nxt = alt_pkg::ST_FULL;
            end else begin
              do_create = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          alt_pkg::OP_TRADE: begin
            if (mfound_r && tfound_r) cmd.trade_go = 1'b1;
            else status_nxt = alt_pkg::ST_NOT_FOUND;
          end
          alt_pkg::OP_ADJUST: begin
            if (mfound_r) cmd.adjust_go = 1'b1;
            else status_nxt = alt_pkg::ST_NOT_FOUND;
          end
          alt_pkg::OP_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            if (!mfound_r) status_nxt = alt_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      alt_pkg::S_RD: begin
        if (load_out) state_nxt = alt_pkg::S_IDLE;
      end
      default: state_nxt = alt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alt_pkg::S_IDLE;
      count_r     <= '0;
      cap_r       <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid) cap_r <= cfg_data;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (in_valid && in_ready) in_r <= in_data;
    if (state_r == alt_pkg::S_LOOK) begin
      mfound_r   <= |mhit;
      tfound_r   <= |thit;
      notional_r <= {32'd0, in_r.price} * {33'd0, in_r.quantity};
    end
    if (load_out) begin
      out_r.status        <= status_r;
      out_r.balance       <= chain[alt_pkg::NumAccounts].found ?
                             chain[alt_pkg::NumAccounts].entry.bal : '0;
      out_r.position      <= chain[alt_pkg::NumAccounts].found ?
                             chain[alt_pkg::NumAccounts].entry.pos : '0;
      out_r.trades_done   <= chain[alt_pkg::NumAccounts].found ?
                             chain[alt_pkg::NumAccounts].entry.cnt : '0;
      out_r.traded_volume <= chain[alt_pkg::NumAccounts].found ?
                             chain[alt_pkg::NumAccounts].entry.vol : '0;
      out_r.sufficient    <= chain[alt_pkg::NumAccounts].found &&
                             ($signed(chain[alt_pkg::NumAccounts].entry.bal) >= in_r.amount);
    end
  end

endmodule

[rtl/core/alt_checker.sv]
// ----------------------------------------------------------------------------
// Account ledger table checker
// Port-level checks on transfer sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "account_ledger_table_macros.svh"

module alt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);

  `ALT_ASSERT_CLK(a_busy_after_in, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `ALT_ASSERT_CLK(a_result_after_work, clk, rst_n, $rose(out_valid) |-> $past(!in_ready))
  `ALT_ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
  `ALT_ASSERT_ALWAYS(a_cfg_open, clk, cfg_ready)

endmodule

bind account_ledger_table alt_checker u_alt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .cfg_ready (cfg_ready)
);
